FILE: src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: src/krs_pkg.sv
// Types and constants of the keyword record search block
package krs_pkg;

	localparam int CHAR_W    = 16;
	localparam int KEY_CHARS = 16;
	localparam int KIDX_W    = 4;
	localparam int LEN_W     = 5;
	localparam int TAG_W     = 16;
	localparam int CNT_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int REG_CHARS = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LO     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_LO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_HI = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HI     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR = 3'd5;

	localparam logic [LEN_W-1:0] KEY_LEN_RST = 5'd1;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [TAG_W-1:0]  tag_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef struct packed {
		logic [LEN_W-1:0]          key_len;
		char_t [KEY_CHARS-1:0]     key_chars;
	} key_cfg_t;

endpackage

FILE: src/krs_ifs.sv
// Valid/ready channel interfaces for input characters and record results
interface krs_in_if;
	logic          valid;
	logic          ready;
	krs_pkg::char_t name_char;
	logic          first_of_record;
	logic          last_of_record;
	krs_pkg::tag_t record_tag;
	logic          clear_count;

	modport source (
		output valid, name_char, first_of_record, last_of_record, record_tag, clear_count,
		input  ready
	);
	modport sink (
		input  valid, name_char, first_of_record, last_of_record, record_tag, clear_count,
		output ready
	);
endinterface

interface krs_out_if;
	logic          valid;
	logic          ready;
	logic          record_matched;
	krs_pkg::tag_t matched_tag;
	krs_pkg::cnt_t match_total;

	modport source (
		output valid, record_matched, matched_tag, match_total,
		input  ready
	);
	modport sink (
		input  valid, record_matched, matched_tag, match_total,
		output ready
	);
endinterface

FILE: src/krs_match.sv
// Comparator bank: does the keyword end at the current character
module krs_match #(
	parameter int KEY_MAX   = 16,
	parameter int WIN_DEPTH = 15
) (
	input  krs_pkg::char_t   cur_char,
	input  krs_pkg::char_t   window [WIN_DEPTH],
	input  krs_pkg::key_cfg_t key_cfg,
	output logic             hit
);

	localparam int CMP_N = krs_pkg::KEY_CHARS;
	localparam int LEN_W = krs_pkg::LEN_W;

	logic [CMP_N-1:0] pos_ok;
	logic             len_ok;

	assign len_ok = (key_cfg.key_len != '0)
		&& (int'(key_cfg.key_len) <= KEY_MAX)
		&& (key_cfg.key_len <= LEN_W'(krs_pkg::KEY_CHARS));

	// position k holds the character k steps back; it must equal key[len-1-k]
	for (genvar k = 0; k < CMP_N; k++) begin : g_cmp
		logic [LEN_W-1:0] key_idx;
		krs_pkg::char_t   key_sel;
		krs_pkg::char_t   seq_c;
		logic             seq_ok;

		assign key_idx = key_cfg.key_len - LEN_W'(k + 1);
		assign key_sel = key_cfg.key_chars[key_idx[krs_pkg::KIDX_W-1:0]];

		if (k == 0) begin : g_cur
			assign seq_c  = cur_char;
			assign seq_ok = 1'b1;
		end else if (k - 1 < WIN_DEPTH) begin : g_win
			assign seq_c  = window[k-1];
			assign seq_ok = 1'b1;
		end else begin : g_none
			assign seq_c  = '0;
			assign seq_ok = 1'b0;
		end

		assign pos_ok[k] = (LEN_W'(k) >= key_cfg.key_len) || (seq_ok && (seq_c == key_sel));
	end

	assign hit = len_ok && (&pos_ok);

endmodule

FILE: src/keyword_record_search.sv
// Latency: a result is valid in the cycle after the item marked last_of_record is accepted.
// Throughput: one character item per cycle while the result register does not stall input; the
// comparator bank checks every keyword character against a sliding window in parallel.
// The result register stalls input only while a held result is not taken.
// Reset (arst_n low) clears window, position, flags, count and output valid; config is reset too.
module keyword_record_search #(
	parameter int KEY_MAX  = 16,
	parameter int NAME_MAX = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	krs_in_if.sink                            in_ch,
	krs_out_if.source                         out_ch,
	input  logic                              cfg_wen,
	input  logic [krs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [krs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int WIN_DEPTH = (KEY_MAX > 1) ? KEY_MAX - 1 : 1;
	localparam int POS_W     = $clog2(NAME_MAX + 1);
	localparam int RC        = krs_pkg::REG_CHARS;

	// configuration
	logic [krs_pkg::LEN_W-1:0]           key_len_q;
	krs_pkg::char_t [krs_pkg::KEY_CHARS-1:0] key_chars_q;
	krs_pkg::char_t                      term_q;
	krs_pkg::key_cfg_t                   key_cfg;

	// record state
	krs_pkg::char_t    window_q [WIN_DEPTH];
	logic [POS_W-1:0]  pos_q;
	logic              ended_q;
	logic              found_q;
	krs_pkg::cnt_t     count_q;

	// result register
	logic              out_valid_q;
	logic              matched_q;
	krs_pkg::tag_t     tag_q;
	krs_pkg::cnt_t     total_q;

	krs_pkg::char_t    win_eff [WIN_DEPTH];
	krs_pkg::char_t    win_nxt [WIN_DEPTH];
	logic [POS_W-1:0]  pos_eff, pos_inc, pos_nxt;
	logic              ended_eff, ended_nxt, found_eff, found_nxt;
	krs_pkg::cnt_t     cnt_eff, cnt_nxt;
	logic              take, stop, key_hit, in_acc;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q   <= krs_pkg::KEY_LEN_RST;
			key_chars_q <= '0;
			term_q      <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				krs_pkg::REG_KEY_LEN:    key_len_q <= cfg_wdata[krs_pkg::LEN_W-1:0];
				krs_pkg::REG_KEY_LO:     key_chars_q[0*RC +: RC] <= cfg_wdata;
				krs_pkg::REG_KEY_MID_LO: key_chars_q[1*RC +: RC] <= cfg_wdata;
				krs_pkg::REG_KEY_MID_HI: key_chars_q[2*RC +: RC] <= cfg_wdata;
				krs_pkg::REG_KEY_HI:     key_chars_q[3*RC +: RC] <= cfg_wdata;
				krs_pkg::REG_TERMINATOR: term_q <= cfg_wdata[krs_pkg::CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	assign key_cfg.key_len   = key_len_q;
	assign key_cfg.key_chars = key_chars_q;

	krs_match #(
		.KEY_MAX   (KEY_MAX),
		.WIN_DEPTH (WIN_DEPTH)
	) u_match (
		.cur_char (in_ch.name_char),
		.window   (win_eff),
		.key_cfg  (key_cfg),
		.hit      (key_hit)
	);

	always_comb begin
		// first_of_record restarts the record before the character is taken
		for (int i = 0; i < WIN_DEPTH; i++) begin
			win_eff[i] = in_ch.first_of_record ? '0 : window_q[i];
		end
		pos_eff   = in_ch.first_of_record ? '0 : pos_q;
		ended_eff = in_ch.first_of_record ? 1'b0 : ended_q;
		found_eff = in_ch.first_of_record ? 1'b0 : found_q;
		cnt_eff   = in_ch.clear_count ? '0 : count_q;

		pos_inc = pos_eff + POS_W'(1);
		stop    = !ended_eff && ((in_ch.name_char == term_q) || (pos_eff >= POS_W'(NAME_MAX)));
		take    = !ended_eff && !stop;

		found_nxt = found_eff
			|| (take && key_hit && (int'(pos_inc) >= int'(key_len_q)));
		pos_nxt   = take ? pos_inc : pos_eff;
		ended_nxt = ended_eff || stop || (take && (pos_inc >= POS_W'(NAME_MAX)));

		win_nxt[0] = take ? in_ch.name_char : win_eff[0];
		for (int i = 1; i < WIN_DEPTH; i++) begin
			win_nxt[i] = take ? win_eff[i-1] : win_eff[i];
		end

		cnt_nxt = cnt_eff;
		if (in_ch.last_of_record && found_nxt && (cnt_eff != krs_pkg::CNT_MAX)) begin
			cnt_nxt = cnt_eff + krs_pkg::cnt_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				window_q[i] <= '0;
			end
			pos_q   <= '0;
			ended_q <= 1'b0;
			found_q <= 1'b0;
			count_q <= '0;
		end else if (in_acc) begin
			count_q <= cnt_nxt;
			if (in_ch.last_of_record) begin
				// record closed: characters are ignored until the next first mark
				for (int i = 0; i < WIN_DEPTH; i++) begin
					window_q[i] <= '0;
				end
				pos_q   <= '0;
				ended_q <= 1'b1;
				found_q <= 1'b0;
			end else begin
				window_q <= win_nxt;
				pos_q    <= pos_nxt;
				ended_q  <= ended_nxt;
				found_q  <= found_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && in_ch.last_of_record) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_ch.last_of_record) begin
			matched_q <= found_nxt;
			tag_q     <= in_ch.record_tag;
			total_q   <= cnt_nxt;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.record_matched = matched_q;
	assign out_ch.matched_tag    = tag_q;
	assign out_ch.match_total    = total_q;

endmodule

FILE: src/krs_chk.sv
// Port-level checker for the keyword record search block, with its bind
`include "assert_macros.svh"

module krs_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          in_last,
	input logic          out_valid,
	input logic          out_ready,
	input logic          out_matched,
	input krs_pkg::tag_t out_tag,
	input krs_pkg::cnt_t out_total
);

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_matched) && $stable(out_tag) && $stable(out_total))

	// an accepted record end gives a result next cycle
	`ASSERT_NEXT(a_last_gives_result, clk, arst_n, in_valid && in_ready && in_last, out_valid)

	// a taken result with no new record end leaves the output empty
	`ASSERT_NEXT(a_no_repeat, clk, arst_n, out_valid && out_ready && !(in_valid && in_ready && in_last), !out_valid)

	// with no result held the block always takes input
	`ASSERT_IMPLIES(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

endmodule

bind keyword_record_search krs_chk u_krs_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_last     (in_ch.last_of_record),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_matched (out_ch.record_matched),
	.out_tag     (out_ch.matched_tag),
	.out_total   (out_ch.match_total)
);

FILE: bench/tb_keyword_record_search.sv
// Self-checking bench for keyword_record_search: drives record names and checks every result
`timescale 1ns / 100ps

typedef struct packed {
	krs_pkg::char_t name_char;
	logic           first;
	logic           last;
	krs_pkg::tag_t  tag;
	logic           clr;
} name_item_t;

typedef struct packed {
	logic           hit;
	krs_pkg::tag_t  tag;
	krs_pkg::cnt_t  total;
} record_result_t;

// Tracks the search state of the block and holds the results still to come
class record_scoreboard #(int KEY_MAX = 16, int NAME_MAX = 16);
	logic [krs_pkg::LEN_W-1:0]      key_len;
	logic [krs_pkg::CFG_DATA_W-1:0] key_regs[4];
	krs_pkg::char_t                 terminator;
	krs_pkg::char_t                 window[KEY_MAX-1];
	int unsigned                    position;
	bit                             name_ended;
	bit                             found;
	krs_pkg::cnt_t                  match_count;
	record_result_t                 pending[$];
	int                             errors;

	function new();
		key_len = krs_pkg::KEY_LEN_RST;
		foreach (key_regs[i]) key_regs[i] = '0;
		terminator = '0;
		match_count = '0;
		errors = 0;
		clear_record();
	endfunction

	function void clear_record();
		foreach (window[i]) window[i] = '0;
		position = 0;
		name_ended = 1'b0;
		found = 1'b0;
	endfunction

	function void set_reg(logic [krs_pkg::CFG_IDX_W-1:0] idx,
			logic [krs_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			krs_pkg::REG_KEY_LEN:    key_len = data[krs_pkg::LEN_W-1:0];
			krs_pkg::REG_KEY_LO:     key_regs[0] = data;
			krs_pkg::REG_KEY_MID_LO: key_regs[1] = data;
			krs_pkg::REG_KEY_MID_HI: key_regs[2] = data;
			krs_pkg::REG_KEY_HI:     key_regs[3] = data;
			krs_pkg::REG_TERMINATOR: terminator = data[krs_pkg::CHAR_W-1:0];
			default: ;
		endcase
	endfunction

	function krs_pkg::char_t key_char(int i);
		return key_regs[i / 4][(i % 4) * 16 +: 16];
	endfunction

	// keyword ends on character c, earlier characters sit in the window
	function bit keyword_ends(krs_pkg::char_t c);
		int n = key_len;
		if (n == 0 || n > KEY_MAX || n > krs_pkg::KEY_CHARS) return 1'b0;
		if (position < n) return 1'b0;
		if (key_char(n - 1) != c) return 1'b0;
		for (int k = 1; k < n; k++)
			if (window[k - 1] != key_char(n - 1 - k)) return 1'b0;
		return 1'b1;
	endfunction

	function void take_char(name_item_t it);
		record_result_t r;
		if (it.clr) match_count = '0;
		if (it.first) clear_record();
		if (!name_ended) begin
			if (it.name_char == terminator || position >= NAME_MAX) begin
				name_ended = 1'b1;
			end else begin
				position++;
				if (keyword_ends(it.name_char)) found = 1'b1;
				for (int i = KEY_MAX - 2; i > 0; i--) window[i] = window[i - 1];
				window[0] = it.name_char;
				if (position >= NAME_MAX) name_ended = 1'b1;
			end
		end
		if (it.last) begin
			if (found && match_count != krs_pkg::CNT_MAX) match_count++;
			r.hit = found;
			r.tag = it.tag;
			r.total = match_count;
			pending.push_back(r);
			clear_record();
			name_ended = 1'b1;
		end
	endfunction

	task report(string what);
		$display("MISMATCH: %s", what);
		errors++;
	endtask

	task check_result(logic hit, krs_pkg::tag_t tag, krs_pkg::cnt_t total);
		record_result_t want;
		if (pending.size() == 0) begin
			report($sformatf("result with none pending, tag %h", tag));
			return;
		end
		want = pending.pop_front();
		if (hit !== want.hit)
			report($sformatf("record_matched %b, want %b (tag %h)", hit, want.hit, want.tag));
		if (tag !== want.tag)
			report($sformatf("matched_tag %h, want %h", tag, want.tag));
		if (total !== want.total)
			report($sformatf("match_total %0d, want %0d (tag %h)", total, want.total, want.tag));
	endtask
endclass

module tb_keyword_record_search;

	localparam int KEY_MAX     = 16;
	localparam int NAME_MAX    = 16;
	localparam int ITEM_TARGET = 1300;
	localparam int LIMIT       = 200000;

	localparam logic [krs_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [krs_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam krs_pkg::char_t CH_A      = 16'h0041;
	localparam krs_pkg::char_t CH_B      = 16'h0042;
	localparam krs_pkg::char_t CH_D      = 16'h0044;
	localparam krs_pkg::char_t CH_DOLLAR = 16'h0024;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_wen;
	logic [krs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [krs_pkg::CFG_DATA_W-1:0] cfg_wdata;

	krs_in_if  in_ch();
	krs_out_if out_ch();

	record_scoreboard #(KEY_MAX, NAME_MAX) board;

	bit                        calm = 1'b0;
	int                        items_sent = 0;
	int                        cycle_count = 0;
	krs_pkg::char_t            keyword[krs_pkg::KEY_CHARS];
	logic [krs_pkg::LEN_W-1:0] key_size;
	krs_pkg::char_t            term_word;

	keyword_record_search #(.KEY_MAX(KEY_MAX), .NAME_MAX(NAME_MAX)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			board.check_result(out_ch.record_matched, out_ch.matched_tag, out_ch.match_total);
	end

	// result side stalls in bursts
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	function automatic krs_pkg::char_t pick_char();
		if ($urandom_range(0, 7) == 0) return krs_pkg::char_t'($urandom);
		return krs_pkg::char_t'($urandom_range(CH_A, CH_D));
	endfunction

	function automatic logic [krs_pkg::CFG_DATA_W-1:0] key_word(int r);
		return {keyword[4*r+3], keyword[4*r+2], keyword[4*r+1], keyword[4*r]};
	endfunction

	task automatic send_char(input krs_pkg::char_t c, input logic first, input logic last,
			input krs_pkg::tag_t tag, input logic clr);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.name_char       <= c;
		in_ch.first_of_record <= first;
		in_ch.last_of_record  <= last;
		in_ch.record_tag      <= tag;
		in_ch.clear_count     <= clr;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		board.take_char('{c, first, last, tag, clr});
		items_sent++;
	endtask

	// well-formed record, keyword planted in about half of them
	task automatic send_record();
		krs_pkg::char_t name[$];
		int    n;
		int    at;
		bit    plant;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
		plant = key_size >= 1 && key_size <= krs_pkg::KEY_CHARS && $urandom_range(0, 1) == 1;
		if (plant && n < key_size) n = key_size;
		repeat (n) name.push_back(pick_char());
		if (plant) begin
			at = $urandom_range(0, n - key_size);
			for (int k = 0; k < key_size; k++) name[at + k] = keyword[k];
		end
		if ($urandom_range(0, 9) == 0) name[$urandom_range(0, n - 1)] = term_word;
		foreach (name[i])
			send_char(name[i], i == 0, i == n - 1, krs_pkg::tag_t'($urandom),
				$urandom_range(0, 39) == 0);
	endtask

	task automatic write_reg(input logic [krs_pkg::CFG_IDX_W-1:0] idx,
			input logic [krs_pkg::CFG_DATA_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	task automatic program_search(input logic [krs_pkg::LEN_W-1:0] len,
			input krs_pkg::char_t term, input bit spare);
		key_size = len;
		term_word = term;
		write_reg(krs_pkg::REG_KEY_LEN, krs_pkg::CFG_DATA_W'(len));
		write_reg(krs_pkg::REG_KEY_LO, key_word(0));
		write_reg(krs_pkg::REG_KEY_MID_LO, key_word(1));
		write_reg(krs_pkg::REG_KEY_MID_HI, key_word(2));
		write_reg(krs_pkg::REG_KEY_HI, key_word(3));
		write_reg(krs_pkg::REG_TERMINATOR, krs_pkg::CFG_DATA_W'(term));
		if (spare) begin
			write_reg(REG_SPARE_A, {$urandom, $urandom});
			write_reg(REG_SPARE_B, {$urandom, $urandom});
		end
		cfg_wen <= 1'b0;
	endtask

	// drain: wait until nothing is pending, then let the last item settle
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int                        phase;
		int                        phase_end;
		logic [krs_pkg::LEN_W-1:0] len;
		krs_pkg::char_t            term;
		board = new();
		arst_n                <= 1'b0;
		cfg_wen               <= 1'b0;
		cfg_index             <= '0;
		cfg_wdata             <= '0;
		in_ch.valid           <= 1'b0;
		in_ch.name_char       <= '0;
		in_ch.first_of_record <= 1'b0;
		in_ch.last_of_record  <= 1'b0;
		in_ch.record_tag      <= '0;
		in_ch.clear_count     <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: keyword "AB", terminator '$'
		foreach (keyword[i]) keyword[i] = krs_pkg::char_t'($urandom);
		keyword[0] = CH_A;
		keyword[1] = CH_B;
		program_search(5'd2, CH_DOLLAR, 1'b1);
		// first record straight after reset has no first mark
		send_char(CH_A, 1'b0, 1'b0, krs_pkg::tag_t'($urandom), 1'b0);
		send_char(CH_B, 1'b0, 1'b1, 16'hFFFF, 1'b0);
		// characters after record end are dropped; count cleared too
		send_char(CH_A, 1'b0, 1'b0, krs_pkg::tag_t'($urandom), 1'b1);
		send_char(CH_B, 1'b0, 1'b1, krs_pkg::tag_t'($urandom), 1'b0);
		// terminator splits the keyword
		send_char(CH_A, 1'b1, 1'b0, krs_pkg::tag_t'($urandom), 1'b0);
		send_char(CH_DOLLAR, 1'b0, 1'b0, krs_pkg::tag_t'($urandom), 1'b0);
		send_char(CH_B, 1'b0, 1'b1, krs_pkg::tag_t'($urandom), 1'b0);
		send_char(CH_A, 1'b1, 1'b1, 16'h0000, 1'b0);
		// keyword straddles the name length limit
		for (int i = 0; i < 15; i++)
			send_char((i % 2) ? 16'h0000 : 16'hFFFF, i == 0, 1'b0,
				krs_pkg::tag_t'($urandom), 1'b0);
		send_char(CH_A, 1'b0, 1'b0, krs_pkg::tag_t'($urandom), 1'b0);
		send_char(CH_B, 1'b0, 1'b1, krs_pkg::tag_t'($urandom), 1'b0);
		settle();

		// run the match count into saturation
		keyword[0] = CH_A;
		program_search(5'd1, 16'h0000, 1'b0);
		repeat (262) send_char(CH_A, 1'b1, 1'b1, krs_pkg::tag_t'($urandom), 1'b0);
		settle();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase % 8)
				0: len = 5'd16;
				1: len = 5'd0;
				2: len = krs_pkg::LEN_W'($urandom_range(17, 31));
				3: len = 5'd1;
				default: len = krs_pkg::LEN_W'($urandom_range(2, 15));
			endcase
			case ($urandom_range(0, 5))
				0: term = 16'h0000;
				1: term = 16'hFFFF;
				2: term = krs_pkg::char_t'($urandom_range(CH_A, CH_D));
				default: term = krs_pkg::char_t'($urandom);
			endcase
			foreach (keyword[i]) keyword[i] = pick_char();
			program_search(len, term, 1'b0);
			phase_end = items_sent + 100;
			while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
				if (items_sent >= ITEM_TARGET - 150) calm = 1'b1;
				if ($urandom_range(0, 7) == 0) begin
					// loose items with random marks
					repeat ($urandom_range(1, 4))
						send_char(krs_pkg::char_t'($urandom), $urandom_range(0, 3) == 0,
							$urandom_range(0, 3) == 0, krs_pkg::tag_t'($urandom),
							$urandom_range(0, 31) == 0);
				end else begin
					send_record();
				end
			end
			settle();
			phase++;
		end

		if (board.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/krs_pkg.sv
src/krs_ifs.sv
src/krs_match.sv
src/keyword_record_search.sv
src/krs_chk.sv
bench/tb_keyword_record_search.sv
